/* rtl/core/spp_pkg.sv */
package spp_pkg;

	// Hold buffer for values at or above the pivot
	localparam int unsigned BUFFER_DEPTH = 63;
	localparam int unsigned CNT_W        = $clog2(BUFFER_DEPTH + 1);
	localparam int unsigned IDX_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

	localparam int unsigned DATA_W = 16;

	// Register port: register i lives at byte address 4*i
	localparam int unsigned PADDR_W     = 3;
	localparam int unsigned PDATA_W     = 32;
	localparam int unsigned REG_IDX_LSB = 2;
	localparam logic        REG_PIVOT   = 1'b0;

	// One classified element on its way from the front end to the back end
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     final_req;
		logic                     below;
	} cmd_t;

endpackage

/* rtl/core/stable_partition_stream.sv */
// Stable partition of a stream of signed 16-bit values around a pivot.
//
// Input channel (valid, stall, value, final_req): one element per beat; the
// beat with final_req high closes the sequence. Result channel (res_valid,
// res_stall, value_res, last, overflow): all elements below the pivot in
// arrival order, then all the others in arrival order. last marks the final
// result of a sequence; overflow is set on that result when a large value
// had to be discarded because the 63-entry hold buffer was full.
// The pivot is written through the APB port at byte address 0 and is read
// back sign-extended; it should only be changed while the block is idle.
//
// Throughput is one element per cycle for every beat but the final one while
// no flush runs and the receiver does not stall. An accepted small value
// passes through the queue into the result register. The final beat starts
// a flush of the held values from the buffer memory at one result per cycle
// while the receiver does not stall, with the first entry read ahead into
// rd_data_q; input beats queue in a two-entry queue and then stall until done.
// When the receiver stalls, the result register holds its beat and the
// block stalls the input once the queue is full. Reset clears the pivot,
// the counters and all valid flags; the buffer contents need no clearing.
module stable_partition_stream (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid,
	output logic                              stall,
	input  logic signed [spp_pkg::DATA_W-1:0] value,
	input  logic                              final_req,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic signed [spp_pkg::DATA_W-1:0] value_res,
	output logic                              last,
	output logic                              overflow,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [spp_pkg::PADDR_W-1:0]       paddr,
	input  logic [spp_pkg::PDATA_W-1:0]       pwdata,
	output logic [spp_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready
);

	// Front end to queue, and queue to back end.
	logic          q_full;
	logic          push;
	spp_pkg::cmd_t push_cmd;
	logic          pop;
	logic          q_valid;
	spp_pkg::cmd_t q_cmd;

	// The front end owns the pivot register and classifies each beat as it
	// is accepted, so a pivot write applies from the next element onwards.
	spp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid),
		.stall     (stall),
		.value     (value),
		.final_req (final_req),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	// The queue lets the front end keep taking beats while the back end
	// waits on the receiver.
	spp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.pop_valid (q_valid),
		.pop_cmd   (q_cmd)
	);

	// The back end emits small values, fills the hold buffer and runs the
	// flush at the end of each sequence.
	spp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.value_res (value_res),
		.last      (last),
		.overflow  (overflow)
	);

endmodule

/* rtl/core/spp_front.sv */
module spp_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid,
	output logic                             stall,
	input  logic signed [spp_pkg::DATA_W-1:0] value,
	input  logic                             final_req,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [spp_pkg::PADDR_W-1:0]      paddr,
	input  logic [spp_pkg::PDATA_W-1:0]      pwdata,
	output logic [spp_pkg::PDATA_W-1:0]      prdata,
	output logic                             pready,
	input  logic                             q_full,
	output logic                             push,
	output spp_pkg::cmd_t                    push_cmd
);

	logic signed [spp_pkg::DATA_W-1:0] pivot_q;
	logic                              sel_pivot;

	assign sel_pivot = (paddr[spp_pkg::REG_IDX_LSB] == spp_pkg::REG_PIVOT);
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pivot_q <= '0;
		end else if (psel && penable && pwrite && pready && sel_pivot) begin
			pivot_q <= pwdata[spp_pkg::DATA_W-1:0];
		end
	end

	// Pivot reads back sign-extended to the bus width.
	always_comb begin
		prdata = '0;
		if (sel_pivot) begin
			prdata = {{(spp_pkg::PDATA_W - spp_pkg::DATA_W){pivot_q[spp_pkg::DATA_W-1]}}, pivot_q};
		end
	end

	assign stall = q_full;
	assign push  = valid && !q_full;

	always_comb begin
		push_cmd.value     = value;
		push_cmd.final_req = final_req;
		push_cmd.below     = (value < pivot_q);
	end

endmodule

/* rtl/core/spp_queue.sv */
module spp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  spp_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          pop_valid,
	output spp_pkg::cmd_t pop_cmd
);

	spp_pkg::cmd_t ent_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_cmd   = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/core/spp_back.sv */
module spp_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  spp_pkg::cmd_t                     q_cmd,
	output logic                              pop,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic signed [spp_pkg::DATA_W-1:0] value_res,
	output logic                              last,
	output logic                              overflow
);

	typedef enum logic [1:0] {
		ST_RUN   = 2'b01,
		ST_FLUSH = 2'b10
	} state_t;

	state_t                          st_q;
	logic [spp_pkg::CNT_W-1:0]       held_cnt_q;
	logic                            dropped_q;
	logic [spp_pkg::CNT_W-1:0]       fl_total_q;
	logic                            fl_ovf_q;
	logic [spp_pkg::CNT_W-1:0]       rd_ptr_q;
	logic                            rd_vld_q;
	logic                            rd_last_q;
	logic [spp_pkg::DATA_W-1:0]      rd_data_q;
	logic [spp_pkg::DATA_W-1:0]      mem_q [spp_pkg::BUFFER_DEPTH];

	logic                            res_valid_q;
	logic signed [spp_pkg::DATA_W-1:0] res_value_q;
	logic                            res_last_q;
	logic                            res_ovf_q;

	logic                            out_free;
	logic                            fits;
	logic                            store;
	logic                            drop;
	logic                            emit_small;
	logic                            small_last;
	logic                            fin;
	logic [spp_pkg::CNT_W-1:0]       next_cnt;
	logic                            next_drop;
	logic                            move;
	logic                            issue;
	logic [spp_pkg::CNT_W-1:0]       rd_ptr_nxt;

	assign out_free   = !res_valid_q || !res_stall;
	assign pop        = (st_q == ST_RUN) && q_valid && (!q_cmd.below || out_free);
	assign fits       = (held_cnt_q < spp_pkg::CNT_W'(spp_pkg::BUFFER_DEPTH));
	assign store      = pop && !q_cmd.below && fits;
	assign drop       = pop && !q_cmd.below && !fits;
	assign emit_small = pop && q_cmd.below;
	assign small_last = q_cmd.final_req && (held_cnt_q == '0);
	assign fin        = pop && q_cmd.final_req;
	assign next_cnt   = store ? (held_cnt_q + spp_pkg::CNT_W'(1)) : held_cnt_q;
	assign next_drop  = dropped_q || drop;

	// Flush: one prefetched entry sits in rd_data_q ahead of the output register.
	assign move       = rd_vld_q && out_free;
	assign issue      = (st_q == ST_FLUSH) && (rd_ptr_q != fl_total_q) && (!rd_vld_q || move);
	assign rd_ptr_nxt = rd_ptr_q + spp_pkg::CNT_W'(1);

	always_ff @(posedge clk) begin
		if (store) begin
			mem_q[held_cnt_q[spp_pkg::IDX_W-1:0]] <= q_cmd.value;
		end
		if (issue) begin
			rd_data_q <= mem_q[rd_ptr_q[spp_pkg::IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_RUN;
			held_cnt_q <= '0;
			dropped_q  <= 1'b0;
			fl_total_q <= '0;
			fl_ovf_q   <= 1'b0;
			rd_ptr_q   <= '0;
			rd_vld_q   <= 1'b0;
			rd_last_q  <= 1'b0;
		end else begin
			unique case (st_q)
				ST_RUN: begin
					if (fin) begin
						held_cnt_q <= '0;
						dropped_q  <= 1'b0;
						if (next_cnt != '0) begin
							st_q       <= ST_FLUSH;
							fl_total_q <= next_cnt;
							fl_ovf_q   <= next_drop;
							rd_ptr_q   <= '0;
						end
					end else begin
						held_cnt_q <= next_cnt;
						dropped_q  <= next_drop;
					end
				end
				ST_FLUSH: begin
					if (issue) begin
						rd_ptr_q  <= rd_ptr_nxt;
						rd_vld_q  <= 1'b1;
						rd_last_q <= (rd_ptr_nxt == fl_total_q);
					end else if (move) begin
						rd_vld_q <= 1'b0;
					end
					if (move && rd_last_q) begin
						st_q <= ST_RUN;
					end
				end
				default: st_q <= ST_RUN;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_small || move) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_small) begin
			res_value_q <= q_cmd.value;
			res_last_q  <= small_last;
			res_ovf_q   <= small_last && dropped_q;
		end else if (move) begin
			res_value_q <= rd_data_q;
			res_last_q  <= rd_last_q;
			res_ovf_q   <= rd_last_q && fl_ovf_q;
		end
	end

	assign res_valid = res_valid_q;
	assign value_res = res_value_q;
	assign last      = res_last_q;
	assign overflow  = res_ovf_q;

endmodule

/* rtl/core/spp_checker.sv */
module spp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              valid,
	input logic                              stall,
	input logic signed [spp_pkg::DATA_W-1:0] value,
	input logic                              final_req,
	input logic                              res_valid,
	input logic                              res_stall,
	input logic signed [spp_pkg::DATA_W-1:0] value_res,
	input logic                              last,
	input logic                              overflow,
	input logic                              psel,
	input logic                              penable,
	input logic                              pwrite,
	input logic [spp_pkg::PADDR_W-1:0]       paddr,
	input logic [spp_pkg::PDATA_W-1:0]       pwdata,
	input logic [spp_pkg::PDATA_W-1:0]       prdata,
	input logic                              pready
);

	// Overflow is only ever reported on the closing result of a sequence.
	a_ovf_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && overflow) |-> last)
		else $error("overflow raised on a result that is not the last");

	// A stalled result beat holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(value_res) &&
			$stable(last) && $stable(overflow)))
		else $error("stalled result beat changed");

	// A stalled input beat holds until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && stall) |=> (valid && $stable(value) && $stable(final_req)))
		else $error("stalled input beat changed");

	// Nothing comes out straight after reset.
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !res_valid)
		else $error("result beat right after reset");

	// A pivot write reads back sign-extended on the next cycle.
	a_pivot_rb: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && !paddr[spp_pkg::REG_IDX_LSB]) |=>
		(paddr[spp_pkg::REG_IDX_LSB] ||
			prdata == {{(spp_pkg::PDATA_W - spp_pkg::DATA_W){$past(pwdata[spp_pkg::DATA_W-1])}},
				$past(pwdata[spp_pkg::DATA_W-1:0])}))
		else $error("pivot read-back mismatch");

endmodule

bind stable_partition_stream spp_checker u_spp_checker (.*);
